// ===== rtl/ibc_pkg.sv =====
package ibc_pkg;

  localparam int IDX_W    = 6;
  localparam int VAL_W    = 32;
  localparam int CNT_W    = 16;
  localparam int MODE_W   = 2;
  localparam int CFG_A_W  = 3;
  localparam int CFG_D_W  = 32;

  localparam logic [MODE_W-1:0] MODE_TRAIN    = 2'd0;
  localparam logic [MODE_W-1:0] MODE_CLASSIFY = 2'd1;
  localparam logic [MODE_W-1:0] MODE_REINIT   = 2'd2;

  // Word index of the single configuration register.
  localparam logic REG_TRAIN_MIN = 1'b0;

  // 100.0 in Q16.16.
  localparam logic [VAL_W-1:0] LOWER_RESET = 32'd6553600;
  localparam logic [VAL_W-1:0] UPPER_RESET = '0;
  localparam logic [CNT_W-1:0] CNT_MAX     = '1;

  // Write request from the control logic to the bound table.
  typedef struct packed {
    logic             en;
    logic             fill;   // 1 stores new bounds, 0 returns the entry to reset
    logic [IDX_W-1:0] addr;
    logic [VAL_W-1:0] lower;
    logic [VAL_W-1:0] upper;
  } bound_wr_t;

endpackage

// ===== rtl/ibc_if.sv =====
interface ibc_in_if;
  import ibc_pkg::*;

  logic              valid;
  logic              ready;
  logic [MODE_W-1:0] mode;
  logic [IDX_W-1:0]  feature_index;
  logic [VAL_W-1:0]  feature_value;
  logic              last_feature;
  logic              is_spam;

  modport source (output valid, mode, feature_index, feature_value, last_feature, is_spam,
                  input ready);
  modport sink (input valid, mode, feature_index, feature_value, last_feature, is_spam,
                output ready);
endinterface

interface ibc_out_if;
  import ibc_pkg::*;

  logic             valid;
  logic             ready;
  logic             predict_spam;
  logic [CNT_W-1:0] ham_passed_count;
  logic [CNT_W-1:0] spam_caught_count;
  logic [CNT_W-1:0] spam_missed_count;
  logic [CNT_W-1:0] ham_flagged_count;

  modport source (output valid, predict_spam, ham_passed_count, spam_caught_count,
                  spam_missed_count, ham_flagged_count, input ready);
  modport sink (input valid, predict_spam, ham_passed_count, spam_caught_count,
                spam_missed_count, ham_flagged_count, output ready);
endinterface

// ===== rtl/ibc_apb_regs.sv =====
module ibc_apb_regs (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [ibc_pkg::CFG_A_W-1:0]   paddr,
  input  logic [ibc_pkg::CFG_D_W-1:0]   pwdata,
  output logic [ibc_pkg::CFG_D_W-1:0]   prdata,
  output logic                          pready,
  output logic [ibc_pkg::VAL_W-1:0]     train_min
);
  import ibc_pkg::*;

  logic [VAL_W-1:0] train_min_r;
  logic [VAL_W-1:0] train_min_nxt;
  logic             sel_train_min;

  assign sel_train_min = (paddr[2] == REG_TRAIN_MIN);
  assign pready        = 1'b1;

  always_comb begin
    train_min_nxt = train_min_r;
    if (psel && penable && pwrite && sel_train_min) begin
      train_min_nxt = pwdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      train_min_r <= '0;
    end else begin
      train_min_r <= train_min_nxt;
    end
  end

  assign prdata    = sel_train_min ? train_min_r : '0;
  assign train_min = train_min_r;

endmodule

// ===== rtl/ibc_bound_mem.sv =====
module ibc_bound_mem #(
  parameter int DEPTH  = 64,
  parameter int ADDR_W = 6
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       rd_en,
  input  logic [ibc_pkg::IDX_W-1:0]  rd_addr,
  output logic [ibc_pkg::VAL_W-1:0]  rd_lower,
  output logic [ibc_pkg::VAL_W-1:0]  rd_upper,
  input  ibc_pkg::bound_wr_t         wr
);
  import ibc_pkg::*;

  // Both bounds of a feature share one word: lower in the top half.
  logic [2*VAL_W-1:0] mem [DEPTH];
  logic [DEPTH-1:0]   entry_valid_r;
  logic [2*VAL_W-1:0] rd_word_r;
  logic               rd_valid_r;
  logic [ADDR_W-1:0]  ra;
  logic [ADDR_W-1:0]  wa;

  assign ra = rd_addr[ADDR_W-1:0];
  assign wa = wr.addr[ADDR_W-1:0];

  always_ff @(posedge clk) begin
    if (wr.en && wr.fill) begin
      mem[wa] <= {wr.lower, wr.upper};
    end
    if (rd_en) begin
      rd_word_r <= mem[ra];
    end
  end

  // An entry that has never been filled since reset or since its last
  // reinitialisation reads as the reset bounds.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      entry_valid_r <= '0;
      rd_valid_r    <= 1'b0;
    end else begin
      if (wr.en) begin
        entry_valid_r[wa] <= wr.fill;
      end
      if (rd_en) begin
        rd_valid_r <= entry_valid_r[ra];
      end
    end
  end

  assign rd_lower = rd_valid_r ? rd_word_r[2*VAL_W-1:VAL_W] : LOWER_RESET;
  assign rd_upper = rd_valid_r ? rd_word_r[VAL_W-1:0]       : UPPER_RESET;

endmodule

// ===== rtl/ibc_ctrl.sv =====
module ibc_ctrl #(
  parameter int FEATURES = 64
) (
  input  logic                      clk,
  input  logic                      rst_n,
  ibc_in_if.sink                    in_chan,
  ibc_out_if.source                 out_chan,
  input  logic [ibc_pkg::VAL_W-1:0] train_min,
  output logic                      rd_en,
  output logic [ibc_pkg::IDX_W-1:0] rd_addr,
  input  logic [ibc_pkg::VAL_W-1:0] rd_lower,
  input  logic [ibc_pkg::VAL_W-1:0] rd_upper,
  output ibc_pkg::bound_wr_t        wr
);
  import ibc_pkg::*;

  localparam int unsigned FEAT_U = FEATURES;

  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] c);
    sat_inc = (c == CNT_MAX) ? c : c + 1'b1;
  endfunction

  logic              busy_r, busy_nxt;
  logic [MODE_W-1:0] mode_r;
  logic [IDX_W-1:0]  idx_r;
  logic [VAL_W-1:0]  val_r;
  logic              last_r;
  logic              spam_r;
  logic              in_range_r;

  logic              outside_r, outside_nxt;
  logic [CNT_W-1:0]  ham_passed_r, ham_passed_nxt;
  logic [CNT_W-1:0]  spam_caught_r, spam_caught_nxt;
  logic [CNT_W-1:0]  spam_missed_r, spam_missed_nxt;
  logic [CNT_W-1:0]  ham_flagged_r, ham_flagged_nxt;

  logic              out_valid_r, out_valid_nxt;
  logic              out_pred_r;
  logic [CNT_W-1:0]  out_ham_passed_r;
  logic [CNT_W-1:0]  out_spam_caught_r;
  logic [CNT_W-1:0]  out_spam_missed_r;
  logic [CNT_W-1:0]  out_ham_flagged_r;

  logic              accept;
  logic              need_out;
  logic              stall;
  logic              done;
  logic              below;
  logic              above;
  logic              hit;
  logic              predict;

  assign accept        = in_chan.valid && in_chan.ready;
  assign in_chan.ready = !busy_r;
  assign rd_en         = accept;
  assign rd_addr       = in_chan.feature_index;

  assign below    = val_r < rd_lower;
  assign above    = val_r > rd_upper;
  assign hit      = in_range_r && (val_r != '0) && (below || above);
  assign predict  = outside_r || hit;
  assign need_out = (mode_r == MODE_CLASSIFY) && last_r;
  // A result can only be loaded once the previous one has gone or is going.
  assign stall    = need_out && out_valid_r && !out_chan.ready;
  assign done     = busy_r && !stall;

  always_comb begin
    busy_nxt        = busy_r;
    outside_nxt     = outside_r;
    ham_passed_nxt  = ham_passed_r;
    spam_caught_nxt = spam_caught_r;
    spam_missed_nxt = spam_missed_r;
    ham_flagged_nxt = ham_flagged_r;
    out_valid_nxt   = out_valid_r && !out_chan.ready;
    wr              = '{en: 1'b0, fill: 1'b0, addr: idx_r,
                        lower: rd_lower, upper: rd_upper};
    if (accept) begin
      busy_nxt = 1'b1;
    end
    if (done) begin
      busy_nxt = 1'b0;
      case (mode_r)
        MODE_TRAIN: begin
          if (in_range_r && !spam_r && (val_r > train_min)) begin
            wr.en    = 1'b1;
            wr.fill  = 1'b1;
            wr.lower = below ? val_r : rd_lower;
            wr.upper = above ? val_r : rd_upper;
          end
        end
        MODE_CLASSIFY: begin
          if (last_r) begin
            outside_nxt   = 1'b0;
            out_valid_nxt = 1'b1;
            if (spam_r) begin
              if (predict) spam_caught_nxt = sat_inc(spam_caught_r);
              else         spam_missed_nxt = sat_inc(spam_missed_r);
            end else begin
              if (predict) ham_flagged_nxt = sat_inc(ham_flagged_r);
              else         ham_passed_nxt  = sat_inc(ham_passed_r);
            end
          end else begin
            outside_nxt = predict;
          end
        end
        MODE_REINIT: begin
          wr.en = in_range_r;
          if (last_r) begin
            outside_nxt     = 1'b0;
            ham_passed_nxt  = '0;
            spam_caught_nxt = '0;
            spam_missed_nxt = '0;
            ham_flagged_nxt = '0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r        <= 1'b0;
      outside_r     <= 1'b0;
      ham_passed_r  <= '0;
      spam_caught_r <= '0;
      spam_missed_r <= '0;
      ham_flagged_r <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      busy_r        <= busy_nxt;
      outside_r     <= outside_nxt;
      ham_passed_r  <= ham_passed_nxt;
      spam_caught_r <= spam_caught_nxt;
      spam_missed_r <= spam_missed_nxt;
      ham_flagged_r <= ham_flagged_nxt;
      out_valid_r   <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      mode_r     <= in_chan.mode;
      idx_r      <= in_chan.feature_index;
      val_r      <= in_chan.feature_value;
      last_r     <= in_chan.last_feature;
      spam_r     <= in_chan.is_spam;
      in_range_r <= (32'(in_chan.feature_index) < FEAT_U);
    end
    if (done && need_out) begin
      out_pred_r        <= predict;
      out_ham_passed_r  <= ham_passed_nxt;
      out_spam_caught_r <= spam_caught_nxt;
      out_spam_missed_r <= spam_missed_nxt;
      out_ham_flagged_r <= ham_flagged_nxt;
    end
  end

  // The result item holds its own copy of the counters, so a reinitialisation
  // that runs while it waits cannot disturb it.
  assign out_chan.valid             = out_valid_r;
  assign out_chan.predict_spam      = out_pred_r;
  assign out_chan.ham_passed_count  = out_ham_passed_r;
  assign out_chan.spam_caught_count = out_spam_caught_r;
  assign out_chan.spam_missed_count = out_spam_missed_r;
  assign out_chan.ham_flagged_count = out_ham_flagged_r;

endmodule

// ===== rtl/interval_box_classifier_top.sv =====
// Interval box classifier.
// The input channel carries one feature of one instance per item: mode,
// index, Q16.16 value, a last-feature mark and the label. Train items widen
// the feature's lower/upper bounds, reinit items restore one entry (and with
// the last mark clear the counters), classify items test the value against
// its interval. A classify item with the last mark yields one result item
// with the prediction and four saturating confusion counters.
// The configuration port holds train_min_value at byte address 0.
// Each item first reads its bound entry from the table memory, then updates
// it and writes it back; a new item is taken only once the previous one is
// done. The item is registered when accepted, and its result is then loaded.
// The result sits in an output register; while it waits, further items that
// produce no result keep flowing, and only an item that needs the output
// register holds until the receiver has taken the previous result.
// Reset clears the counters, the instance flag and the per-entry valid bits,
// so every table entry reads as its reset bounds at once; no clearing pass.
module interval_box_classifier_top #(
  parameter int FEATURES = 64
) (
  input  logic                        clk,
  input  logic                        rst_n,
  ibc_in_if.sink                      in_chan,
  ibc_out_if.source                   out_chan,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [ibc_pkg::CFG_A_W-1:0] paddr,
  input  logic [ibc_pkg::CFG_D_W-1:0] pwdata,
  output logic [ibc_pkg::CFG_D_W-1:0] prdata,
  output logic                        pready
);
  import ibc_pkg::*;

  // Only 64 indices are addressable, so at most 64 table entries exist.
  localparam int DEPTH  = (FEATURES < (1 << IDX_W)) ? FEATURES : (1 << IDX_W);
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [VAL_W-1:0] train_min;
  logic             rd_en;
  logic [IDX_W-1:0] rd_addr;
  logic [VAL_W-1:0] rd_lower;
  logic [VAL_W-1:0] rd_upper;
  bound_wr_t        wr;

  ibc_apb_regs u_regs (
    .clk       (clk),
    .rst_n     (rst_n),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .train_min (train_min)
  );

  ibc_bound_mem #(
    .DEPTH  (DEPTH),
    .ADDR_W (ADDR_W)
  ) u_mem (
    .clk      (clk),
    .rst_n    (rst_n),
    .rd_en    (rd_en),
    .rd_addr  (rd_addr),
    .rd_lower (rd_lower),
    .rd_upper (rd_upper),
    .wr       (wr)
  );

  ibc_ctrl #(
    .FEATURES (FEATURES)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_chan   (in_chan),
    .out_chan  (out_chan),
    .train_min (train_min),
    .rd_en     (rd_en),
    .rd_addr   (rd_addr),
    .rd_lower  (rd_lower),
    .rd_upper  (rd_upper),
    .wr        (wr)
  );

endmodule

// ===== sim/interval_box_classifier_top_tb.sv =====
`timescale 1ns / 100ps

module interval_box_classifier_top_tb;
  import ibc_pkg::*;

  localparam int FEATURES = 64;
  localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

  typedef struct {
    logic [MODE_W-1:0] mode;
    logic [IDX_W-1:0]  idx;
    logic [VAL_W-1:0]  value;
    logic              last;
    logic              spam;
  } feature_item_t;

  typedef struct {
    logic             predict;
    logic [CNT_W-1:0] ham_passed;
    logic [CNT_W-1:0] spam_caught;
    logic [CNT_W-1:0] spam_missed;
    logic [CNT_W-1:0] ham_flagged;
  } verdict_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [CFG_A_W-1:0] paddr = '0;
  logic [CFG_D_W-1:0] pwdata = '0;
  logic [CFG_D_W-1:0] prdata;
  logic pready;

  ibc_in_if  in_chan ();
  ibc_out_if out_chan ();

  interval_box_classifier_top #(.FEATURES(FEATURES)) u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Predictor state: the interval table, the instance flag and the counters.
  logic [VAL_W-1:0] lower_tbl [FEATURES];
  logic [VAL_W-1:0] upper_tbl [FEATURES];
  logic             inst_outside;
  logic [CNT_W-1:0] cnt_ham_passed, cnt_spam_caught, cnt_spam_missed, cnt_ham_flagged;
  logic [VAL_W-1:0] train_min;

  feature_item_t pending_items[$];
  verdict_t      expected_verdicts[$];
  feature_item_t cur_item;
  verdict_t      next_verdict;

  bit idle_on = 1'b1;
  bit hold_done = 1'b0;
  int hold_left = 0;
  int items_accepted = 0;
  int results_checked = 0;
  int mismatches = 0;
  int cfg_writes = 0;

  initial begin
    for (int i = 0; i < FEATURES; i++) begin
      lower_tbl[i] = LOWER_RESET;
      upper_tbl[i] = UPPER_RESET;
    end
    inst_outside = 1'b0;
    cnt_ham_passed = '0;
    cnt_spam_caught = '0;
    cnt_spam_missed = '0;
    cnt_ham_flagged = '0;
    train_min = '0;
  end

  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] c);
    return (c == CNT_MAX) ? c : c + 1'b1;
  endfunction

  task automatic apply_feature(input feature_item_t it);
    verdict_t v;
    case (it.mode)
      MODE_TRAIN: begin
        if (!it.spam && it.value > train_min) begin
          if (it.value < lower_tbl[it.idx]) lower_tbl[it.idx] = it.value;
          if (it.value > upper_tbl[it.idx]) upper_tbl[it.idx] = it.value;
        end
      end
      MODE_REINIT: begin
        lower_tbl[it.idx] = LOWER_RESET;
        upper_tbl[it.idx] = UPPER_RESET;
        if (it.last) begin
          cnt_ham_passed = '0;
          cnt_spam_caught = '0;
          cnt_spam_missed = '0;
          cnt_ham_flagged = '0;
          inst_outside = 1'b0;
        end
      end
      MODE_CLASSIFY: begin
        if (it.value != '0 &&
            (it.value < lower_tbl[it.idx] || it.value > upper_tbl[it.idx]))
          inst_outside = 1'b1;
        if (it.last) begin
          v.predict = inst_outside;
          inst_outside = 1'b0;
          if (it.spam) begin
            if (v.predict) cnt_spam_caught = sat_inc(cnt_spam_caught);
            else cnt_spam_missed = sat_inc(cnt_spam_missed);
          end else begin
            if (v.predict) cnt_ham_flagged = sat_inc(cnt_ham_flagged);
            else cnt_ham_passed = sat_inc(cnt_ham_passed);
          end
          v.ham_passed = cnt_ham_passed;
          v.spam_caught = cnt_spam_caught;
          v.spam_missed = cnt_spam_missed;
          v.ham_flagged = cnt_ham_flagged;
          expected_verdicts.push_back(v);
        end
      end
      default: ;
    endcase
  endtask

  task automatic report_mismatch(input string what, input logic [31:0] want,
                                 input logic [31:0] got);
    mismatches++;
    $display("Mismatch in %s at result %0d: expected %0h, got %0h",
             what, results_checked, want, got);
  endtask

  // Driver: a new item is offered once the previous one has been taken.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_chan.valid         <= 1'b0;
      in_chan.mode          <= MODE_TRAIN;
      in_chan.feature_index <= '0;
      in_chan.feature_value <= '0;
      in_chan.last_feature  <= 1'b0;
      in_chan.is_spam       <= 1'b0;
    end else if (!in_chan.valid || in_chan.ready) begin
      if (in_chan.valid) begin
        apply_feature(cur_item);
        items_accepted++;
      end
      if (pending_items.size() != 0 && !(idle_on && $urandom_range(0, 99) < 9)) begin
        cur_item = pending_items.pop_front();
        in_chan.valid         <= 1'b1;
        in_chan.mode          <= cur_item.mode;
        in_chan.feature_index <= cur_item.idx;
        in_chan.feature_value <= cur_item.value;
        in_chan.last_feature  <= cur_item.last;
        in_chan.is_spam       <= cur_item.spam;
      end else begin
        in_chan.valid <= 1'b0;
      end
    end
  end

  // Monitor: checks each result item and, once, holds off for a long stretch.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_chan.ready <= 1'b0;
    end else begin
      if (out_chan.valid && out_chan.ready) begin
        if (expected_verdicts.size() == 0) begin
          report_mismatch("unexpected result", '0, {31'b0, out_chan.predict_spam});
        end else begin
          next_verdict = expected_verdicts.pop_front();
          if (out_chan.predict_spam !== next_verdict.predict)
            report_mismatch("predict_spam", 32'(next_verdict.predict),
                            32'(out_chan.predict_spam));
          if (out_chan.ham_passed_count !== next_verdict.ham_passed)
            report_mismatch("ham_passed_count", 32'(next_verdict.ham_passed),
                            32'(out_chan.ham_passed_count));
          if (out_chan.spam_caught_count !== next_verdict.spam_caught)
            report_mismatch("spam_caught_count", 32'(next_verdict.spam_caught),
                            32'(out_chan.spam_caught_count));
          if (out_chan.spam_missed_count !== next_verdict.spam_missed)
            report_mismatch("spam_missed_count", 32'(next_verdict.spam_missed),
                            32'(out_chan.spam_missed_count));
          if (out_chan.ham_flagged_count !== next_verdict.ham_flagged)
            report_mismatch("ham_flagged_count", 32'(next_verdict.ham_flagged),
                            32'(out_chan.ham_flagged_count));
        end
        results_checked++;
      end
      if (!hold_done && results_checked >= 40) begin
        hold_left = 300;
        hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_chan.ready <= 1'b0;
      end else begin
        out_chan.ready <= !(idle_on && $urandom_range(0, 99) < 9);
      end
    end
  end

  task automatic push_item(input logic [MODE_W-1:0] mode, input logic [IDX_W-1:0] idx,
                           input logic [VAL_W-1:0] value, input logic last,
                           input logic spam);
    feature_item_t it;
    it.mode = mode;
    it.idx = idx;
    it.value = value;
    it.last = last;
    it.spam = spam;
    pending_items.push_back(it);
  endtask

  // Mostly a small pool of features, so that trained intervals get hit again.
  function automatic logic [IDX_W-1:0] rand_index();
    return IDX_W'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 63)
                                              : $urandom_range(0, 15));
  endfunction

  function automatic logic [VAL_W-1:0] rand_value(input logic [VAL_W-1:0] thresh);
    int r;
    r = $urandom_range(0, 99);
    if (r < 10) return '0;
    else if (r < 14) return '1;
    else if (r < 20) return thresh;
    else if (r < 26) return thresh + 1'b1;
    else if (r < 40) return $urandom;
    else return $urandom_range(32'h0000_8000, 32'h00C8_0000);
  endfunction

  task automatic queue_mixed_traffic(input int target);
    int queued;
    int r;
    int n;
    logic spam;
    queued = 0;
    while (queued < target) begin
      r = $urandom_range(0, 99);
      n = $urandom_range(1, 6);
      spam = 1'($urandom_range(0, 1));
      if (r < 35) begin
        spam = ($urandom_range(0, 99) < 15);
        for (int k = 0; k < n; k++)
          push_item(MODE_TRAIN, rand_index(), rand_value(train_min), k == n - 1, spam);
        queued += n;
      end else if (r < 82) begin
        for (int k = 0; k < n; k++)
          push_item(MODE_CLASSIFY, rand_index(), rand_value(train_min), k == n - 1, spam);
        queued += n;
      end else if (r < 90) begin
        push_item(MODE_REINIT, rand_index(), $urandom, $urandom_range(0, 3) == 0,
                  1'($urandom_range(0, 1)));
        queued++;
      end else if (r < 95) begin
        push_item(MODE_UNUSED, IDX_W'($urandom_range(0, 63)), $urandom,
                  1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
        queued++;
      end else begin
        // An instance cut short, followed by a stray train item.
        for (int k = 0; k < n; k++)
          push_item(MODE_CLASSIFY, rand_index(), rand_value(train_min), 1'b0, spam);
        push_item(MODE_TRAIN, rand_index(), rand_value(train_min),
                  1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
        queued += n + 1;
      end
    end
  endtask

  task automatic write_train_min(input logic [VAL_W-1:0] value);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {REG_TRAIN_MIN, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    train_min = value;
    cfg_writes++;
  endtask

  // Items without a result may still be in the pipeline, hence the tail.
  task automatic drain_block();
    while (pending_items.size() != 0 || in_chan.valid || expected_verdicts.size() != 0)
      @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  initial begin
    #(12 * 4_000_000);
    $display("FAILURE");
    $finish;
  end

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    write_train_min('0);
    // A zero value never exceeds a zero threshold, so the first item trains nothing.
    push_item(MODE_TRAIN, 6'd0, 32'h0000_0000, 1'b0, 1'b0);
    push_item(MODE_TRAIN, 6'd0, 32'h0001_0000, 1'b0, 1'b0);
    push_item(MODE_TRAIN, 6'd0, 32'h0020_0000, 1'b0, 1'b0);
    push_item(MODE_TRAIN, 6'd1, 32'h0005_0000, 1'b0, 1'b1);
    push_item(MODE_TRAIN, 6'd63, 32'hFFFF_FFFF, 1'b0, 1'b0);
    push_item(MODE_TRAIN, 6'd2, 32'h0000_0001, 1'b1, 1'b0);
    push_item(MODE_CLASSIFY, 6'd0, 32'h0010_0000, 1'b0, 1'b1);
    push_item(MODE_CLASSIFY, 6'd1, 32'h0000_0000, 1'b0, 1'b1);
    push_item(MODE_CLASSIFY, 6'd2, 32'h0000_0001, 1'b1, 1'b1);
    push_item(MODE_CLASSIFY, 6'd1, 32'h0000_0005, 1'b1, 1'b1);
    push_item(MODE_CLASSIFY, 6'd0, 32'h0030_0000, 1'b0, 1'b0);
    push_item(MODE_UNUSED, 6'd0, 32'hFFFF_FFFF, 1'b1, 1'b1);
    push_item(MODE_TRAIN, 6'd3, 32'h0000_0007, 1'b1, 1'b0);
    push_item(MODE_CLASSIFY, 6'd63, 32'hFFFF_FFFF, 1'b1, 1'b0);
    push_item(MODE_CLASSIFY, 6'd0, 32'h0001_0000, 1'b1, 1'b0);
    push_item(MODE_REINIT, 6'd0, 32'h0000_0000, 1'b0, 1'b0);
    push_item(MODE_CLASSIFY, 6'd0, 32'h0001_0000, 1'b1, 1'b0);
    push_item(MODE_CLASSIFY, 6'd5, 32'h0000_0003, 1'b0, 1'b1);
    push_item(MODE_REINIT, 6'd5, 32'h0000_0000, 1'b1, 1'b1);
    push_item(MODE_CLASSIFY, 6'd2, 32'h0000_0001, 1'b1, 1'b0);
    drain_block();

    write_train_min($urandom_range(0, 32'h0010_0000));
    queue_mixed_traffic(295);
    drain_block();
    write_train_min('1);
    queue_mixed_traffic(295);
    drain_block();
    write_train_min($urandom);
    queue_mixed_traffic(295);
    drain_block();

    // One long stretch in which neither side ever idles.
    idle_on = 1'b0;
    write_train_min(LOWER_RESET);
    queue_mixed_traffic(295);
    drain_block();

    idle_on = 1'b1;
    push_item(MODE_REINIT, 6'd10, 32'h0000_0000, 1'b1, 1'b0);
    queue_mixed_traffic(40);
    drain_block();

    $display("Run covered %0d items of mixed train, classify, reinit and unused-mode traffic",
             items_accepted);
    $display("under %0d threshold settings with a long receiver stall; %0d results checked.",
             cfg_writes, results_checked);
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/ibc_pkg.sv
rtl/ibc_if.sv
rtl/ibc_apb_regs.sv
rtl/ibc_bound_mem.sv
rtl/ibc_ctrl.sv
rtl/interval_box_classifier_top.sv
sim/interval_box_classifier_top_tb.sv
